>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// condition that holds at every edge
`define ASRB_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// condition that holds in the cycle after a trigger
`define ASRB_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);
`else
`define ASRB_ASSERT(name, cond, msg)
`define ASRB_ASSERT_NEXT(name, trig, cond, msg)
`endif

`endif

>>> rtl/asrb_pkg.sv
// ----------------------------------------------------------------------------
// asrb_pkg
// shared types and constants of the audio sample ring buffer
// ----------------------------------------------------------------------------
`default_nettype none

package asrb_pkg;

  // operation codes of an input item
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // most results one read request may produce
  localparam int RESULT_LIMIT = 64;

  // reset value of the channel count register
  localparam logic [1:0] CHANNEL_COUNT_RESET = 2'd2;

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    sample_t     sample_out;
    logic        accepted;
    logic        padded;
    logic        last;
    logic [15:0] underrun_total;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/asrb_if.sv
// ----------------------------------------------------------------------------
// asrb channel interfaces
// valid/ready channels for input items, result items and the config write
// ----------------------------------------------------------------------------
`default_nettype none

interface asrb_in_if
  import asrb_pkg::*;
;
  logic        valid;
  logic        ready;
  logic        operation;
  sample_t     sample_in;
  logic [5:0]  frames;

  modport source (output valid, output operation, output sample_in, output frames,
                  input ready);
  modport sink   (input valid, input operation, input sample_in, input frames,
                  output ready);
endinterface

interface asrb_out_if
  import asrb_pkg::*;
;
  logic        valid;
  logic        ready;
  sample_t     sample_out;
  logic        accepted;
  logic        padded;
  logic        last;
  logic [15:0] underrun_total;

  modport source (output valid, output sample_out, output accepted, output padded,
                  output last, output underrun_total, input ready);
  modport sink   (input valid, input sample_out, input accepted, input padded,
                  input last, input underrun_total, output ready);
endinterface

interface asrb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] channel_count;

  modport source (output valid, output channel_count, input ready);
  modport sink   (input valid, input channel_count, output ready);
endinterface

`default_nettype wire

>>> rtl/audio_sample_ring_buffer.sv
// ----------------------------------------------------------------------------
// audio_sample_ring_buffer
// write item: its result passes the issue stage, then leaves through the output queue
// read item: request taken, then 1 result per cycle while the queue has room, set by
//   the single read port of the sample memory; results pass the issue stage and queue
// reset: pointers, fill count, underrun counter and queue cleared at once,
//   channel count to 2; the sample memory is not cleared, no sweep needed
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module audio_sample_ring_buffer
  import asrb_pkg::*;
#(
  parameter int CAPACITY   = 32768,
  parameter int MAX_FRAMES = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  asrb_in_if.sink    in_ch,
  asrb_out_if.source out_ch,
  asrb_cfg_if.sink   cfg_ch
);

  // pointer and fill count widths follow the store depth
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = (FW > 7) ? FW : 7;

  localparam logic [PW-1:0] PTR_LAST  = PW'(CAPACITY - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(CAPACITY);
  localparam logic [6:0]    FRAMES_CAP = 7'(MAX_FRAMES);
  localparam logic [7:0]    NEED_CAP   = 8'(RESULT_LIMIT);

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  // sample memory, one write and one registered read port
  sample_t mem [CAPACITY];
  sample_t mem_rdata_r;

  // control state
  state_t        state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [15:0]   underrun_r, underrun_nxt;
  logic [1:0]    chan_r, chan_nxt;
  logic [6:0]    rem_r, rem_nxt;     // results still to issue in this request
  logic [6:0]    avail_r, avail_nxt; // of those, how many come from memory

  // issue stage: one result, on a read waiting for the memory read data
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_mem_r, s1_mem_nxt;
  result_t       s1_res_r, s1_res_nxt;

  // two-entry output queue decouples the consumer from the memory latency
  result_t       q_r [2];
  logic          q_wr_r, q_wr_nxt;
  logic          q_rd_r, q_rd_nxt;
  logic [1:0]    occ_r, occ_nxt;

  logic          pop;
  logic          push;
  logic [2:0]    in_flight;
  logic          issue_ok;
  logic          in_acc;
  logic          rd_issue;
  logic          mem_rd;
  logic          mem_wr;
  logic          full;
  logic [6:0]    frames_sat;
  logic [7:0]    need_raw;
  logic [6:0]    need;
  logic [CW-1:0] fill_ext;
  logic [CW-1:0] need_ext;
  logic [CW-1:0] have_ext;
  result_t       push_res;

  // handshake side
  assign pop       = (occ_r != 2'd0) && out_ch.ready;
  assign push      = s1_valid_r;
  assign in_flight = {1'b0, occ_r} + {2'b00, s1_valid_r};
  // a new result may enter the issue stage when the queue is sure to have room
  assign issue_ok  = (in_flight < 3'd2) || ((in_flight == 3'd2) && pop);

  // nothing is taken while reset is held
  assign in_ch.ready  = rst_n && (state_r == ST_IDLE) && issue_ok;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign rd_issue     = (state_r == ST_READ) && issue_ok;
  assign cfg_ch.ready = rst_n;

  assign full   = (fill_r == FILL_FULL);
  assign mem_wr = in_acc && (in_ch.operation == OP_WRITE) && !full;
  assign mem_rd = rd_issue && (avail_r != 7'd0);

  // request length: frames saturated, doubled for a channel count of 2 or more, capped
  assign frames_sat = ({1'b0, in_ch.frames} > FRAMES_CAP) ? FRAMES_CAP
                                                          : {1'b0, in_ch.frames};
  assign need_raw   = chan_r[1] ? {frames_sat, 1'b0} : {1'b0, frames_sat};
  assign need       = (need_raw > NEED_CAP) ? NEED_CAP[6:0] : need_raw[6:0];
  assign fill_ext   = CW'(fill_r);
  assign need_ext   = CW'(need);
  assign have_ext   = (fill_ext < need_ext) ? fill_ext : need_ext;

  // memory data joins its result as it enters the queue
  always_comb begin
    push_res = s1_res_r;
    if (s1_mem_r) begin
      push_res.sample_out = mem_rdata_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    fill_nxt     = fill_r;
    underrun_nxt = underrun_r;
    chan_nxt     = chan_r;
    rem_nxt      = rem_r;
    avail_nxt    = avail_r;
    s1_valid_nxt = 1'b0;
    s1_mem_nxt   = 1'b0;
    s1_res_nxt   = s1_res_r;
    q_wr_nxt     = q_wr_r ^ push;
    q_rd_nxt     = q_rd_r ^ pop;
    occ_nxt      = occ_r + {1'b0, push} - {1'b0, pop};

    // register write; the user must write only while idle, the block does not enforce it
    if (cfg_ch.valid) begin
      chan_nxt = cfg_ch.channel_count;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.operation == OP_WRITE) begin
            // a write item gives its one result straight away
            if (!full) begin
              wp_nxt   = (wp_r == PTR_LAST) ? '0 : wp_r + PW'(1);
              fill_nxt = fill_r + FW'(1);
            end
            s1_valid_nxt              = 1'b1;
            s1_res_nxt.sample_out     = '0;
            s1_res_nxt.accepted       = !full;
            s1_res_nxt.padded         = 1'b0;
            s1_res_nxt.last           = 1'b1;
            s1_res_nxt.underrun_total = underrun_r;
          end else if (need != 7'd0) begin
            // short request: count once, saturating
            if ((have_ext < need_ext) && (underrun_r != 16'hFFFF)) begin
              underrun_nxt = underrun_r + 16'd1;
            end
            rem_nxt   = need;
            avail_nxt = have_ext[6:0];
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (rd_issue) begin
          s1_valid_nxt              = 1'b1;
          s1_res_nxt.sample_out     = '0;
          s1_res_nxt.accepted       = 1'b0;
          s1_res_nxt.padded         = (avail_r == 7'd0);
          s1_res_nxt.last           = (rem_r == 7'd1);
          s1_res_nxt.underrun_total = underrun_r;
          if (avail_r != 7'd0) begin
            s1_mem_nxt = 1'b1;
            rp_nxt     = (rp_r == PTR_LAST) ? '0 : rp_r + PW'(1);
            fill_nxt   = fill_r - FW'(1);
            avail_nxt  = avail_r - 7'd1;
          end
          rem_nxt = rem_r - 7'd1;
          if (rem_r == 7'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wp_r       <= '0;
      rp_r       <= '0;
      fill_r     <= '0;
      underrun_r <= '0;
      chan_r     <= CHANNEL_COUNT_RESET;
      rem_r      <= '0;
      avail_r    <= '0;
      s1_valid_r <= 1'b0;
      s1_mem_r   <= 1'b0;
      q_wr_r     <= 1'b0;
      q_rd_r     <= 1'b0;
      occ_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      fill_r     <= fill_nxt;
      underrun_r <= underrun_nxt;
      chan_r     <= chan_nxt;
      rem_r      <= rem_nxt;
      avail_r    <= avail_nxt;
      s1_valid_r <= s1_valid_nxt;
      s1_mem_r   <= s1_mem_nxt;
      q_wr_r     <= q_wr_nxt;
      q_rd_r     <= q_rd_nxt;
      occ_r      <= occ_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    s1_res_r <= s1_res_nxt;
    if (push) begin
      q_r[q_wr_r] <= push_res;
    end
  end

  // writes happen only while idle and reads only while streaming, so the
  // two ports never touch the same entry in one cycle
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wp_r] <= in_ch.sample_in;
    end
    if (mem_rd) begin
      mem_rdata_r <= mem[rp_r];
    end
  end

  // output side reads the queue head
  assign out_ch.valid          = (occ_r != 2'd0);
  assign out_ch.sample_out     = q_r[q_rd_r].sample_out;
  assign out_ch.accepted       = q_r[q_rd_r].accepted;
  assign out_ch.padded         = q_r[q_rd_r].padded;
  assign out_ch.last           = q_r[q_rd_r].last;
  assign out_ch.underrun_total = q_r[q_rd_r].underrun_total;

  // queue plus issue stage never hold more than the queue depth
  `ASRB_ASSERT(a_queue_room, in_flight <= 3'd2, "output queue overcommitted")
  // fill count stays within the store
  `ASRB_ASSERT(a_fill_bound, fill_r <= FILL_FULL, "fill count above capacity")
  // a memory read only happens with data buffered
  `ASRB_ASSERT(a_read_has_data, !mem_rd || (fill_r != '0), "read from empty store")
  // issuing the last result of a request returns to idle
  `ASRB_ASSERT_NEXT(a_req_end, rd_issue && (rem_r == 7'd1), state_r == ST_IDLE, "request did not end after its last result")

endmodule

`default_nettype wire
